@@ rtl/c_source_line_classifier_top_macros.svh @@
// Assertion macros used by the line classifier top level.
`ifndef C_SOURCE_LINE_CLASSIFIER_TOP_MACROS_SVH
`define C_SOURCE_LINE_CLASSIFIER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSLC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CSLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/cslc_pkg.sv @@
// Package with codes, state type and constants of the C source line classifier.
package cslc_pkg;

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_SLASH  = 3'd1;
    localparam logic [2:0] MODE_LINE   = 3'd2;
    localparam logic [2:0] MODE_BLOCK  = 3'd3;
    localparam logic [2:0] MODE_STAR   = 3'd4;

    localparam logic [1:0] TYPE_CODE    = 2'd0;
    localparam logic [1:0] TYPE_COMMENT = 2'd1;
    localparam logic [1:0] TYPE_DOC     = 2'd2;
    localparam logic [1:0] TYPE_PREPROC = 2'd3;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_EOL  = 1'b1;

    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_HASH      = 8'h23;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;

    localparam logic [2:0] DOC_FULL     = 3'd3;
    localparam logic [2:0] DOC_MISMATCH = 3'd4;

    typedef struct packed {
        logic [2:0]  mode;
        logic        began_in_block;
        logic [1:0]  prev_type;
        logic        prev_bs;
        logic        last_bs;
        logic [2:0]  doc_prog;
        logic        lead;
        logic        first_hash;
        logic        has_content;
        logic [15:0] line_cnt;
    } state_t;

    localparam state_t STATE_RESET = '{
        mode:           MODE_NORMAL,
        began_in_block: 1'b0,
        prev_type:      TYPE_CODE,
        prev_bs:        1'b0,
        last_bs:        1'b0,
        doc_prog:       3'd0,
        lead:           1'b1,
        first_hash:     1'b0,
        has_content:    1'b0,
        line_cnt:       16'd0
    };

endpackage

@@ rtl/c_source_line_classifier_top.sv @@
// Top level of the C source line classifier with its state and result registers.
//
// Channel  Dir  Signals                           Meaning
// s_       in   s_tvalid s_tready s_tdata s_tuser  one source byte or an end of line
// m_       out  m_tvalid m_tready m_tdata          one classified line per end of line
//
// One transaction is taken per cycle while s_tready is high; the comment state register updates in that cycle.
// A line result appears in the output register the cycle after its end-of-line transaction.
// Reset brings the comment state to normal code mode and the line index to zero.
// The input is held off only while a result waits in the output register and m_tready is low.
`include "c_source_line_classifier_top_macros.svh"

module c_source_line_classifier_top
    import cslc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] ch
    input  logic        s_tuser,   // [0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // [1:0] line_type, [2] continued, [18:3] line_index
);

    state_t      state_reg;
    state_t      state_next;
    logic [1:0]  line_type;
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [18:0] result_reg;
    logic        s_accept;
    logic        eol_accept;

    cslc_step u_step (
        .state      (state_reg),
        .op         (s_tuser),
        .ch         (s_tdata),
        .state_next (state_next),
        .line_type  (line_type)
    );

    assign s_tready   = !m_tvalid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;
    assign eol_accept = s_accept && (s_tuser == OP_EOL);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (eol_accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= STATE_RESET;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (s_accept) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (eol_accept) begin
            result_reg <= {state_reg.line_cnt, state_reg.prev_bs, line_type};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, result_reg};

    `CSLC_ASSERT_SAME(a_result_from_eol, m_tvalid_reg && !$past(m_tvalid_reg), $past(eol_accept))
    `CSLC_ASSERT_NEXT(a_line_count_step, eol_accept,
        state_reg.line_cnt == 16'($past(state_reg.line_cnt) + 16'd1))
    `CSLC_ASSERT_NEXT(a_preproc_mode_normal,
        eol_accept && !state_reg.prev_bs && line_type == TYPE_PREPROC,
        state_reg.mode == MODE_NORMAL && !state_reg.began_in_block)

endmodule

@@ rtl/cslc_step.sv @@
// Next-state and line classification logic for one transaction.
module cslc_step
    import cslc_pkg::*;
(
    input  state_t     state,
    input  logic       op,
    input  logic [7:0] ch,
    output state_t     state_next,
    output logic [1:0] line_type
);

    logic       blank;
    logic       hc;
    logic       in_block;
    logic [7:0] doc_ch;

    always_comb begin
        blank = ch inside {CH_SPACE, CH_CR, CH_TAB};
        doc_ch = (state.doc_prog == 3'd0) ? CH_SLASH : CH_STAR;
        state_next = state;
        hc = state.has_content || (state.mode == MODE_SLASH);
        in_block = (state.mode == MODE_BLOCK) || (state.mode == MODE_STAR);
        line_type = TYPE_CODE;

        if (op == OP_CHAR) begin
            case (state.mode)
                MODE_SLASH: begin
                    if (ch == CH_SLASH) begin
                        state_next.mode = MODE_LINE;
                    end else if (ch == CH_STAR) begin
                        state_next.mode = MODE_BLOCK;
                    end else begin
                        state_next.has_content = 1'b1;
                        state_next.mode = MODE_NORMAL;
                    end
                end
                MODE_LINE: begin
                end
                MODE_BLOCK: begin
                    if (ch == CH_STAR) begin
                        state_next.mode = MODE_STAR;
                    end
                end
                MODE_STAR: begin
                    if (ch == CH_SLASH) begin
                        state_next.mode = MODE_NORMAL;
                    end else if (ch != CH_STAR) begin
                        state_next.mode = MODE_BLOCK;
                    end
                end
                default: begin
                    if (ch == CH_SLASH) begin
                        state_next.mode = MODE_SLASH;
                    end else if (!blank) begin
                        state_next.has_content = 1'b1;
                    end
                end
            endcase

            if (state.lead && ch != CH_SPACE && ch != CH_TAB) begin
                state_next.lead = 1'b0;
                state_next.first_hash = (ch == CH_HASH);
            end

            if (state.doc_prog < DOC_FULL) begin
                state_next.doc_prog = (ch == doc_ch) ? state.doc_prog + 3'd1 : DOC_MISMATCH;
            end

            state_next.last_bs = (ch == CH_BACKSLASH);
        end else begin
            if (state.prev_bs) begin
                line_type = state.prev_type;
            end else if (!state.began_in_block && state.first_hash) begin
                line_type = TYPE_PREPROC;
                in_block = 1'b0;
            end else if (!hc) begin
                if (state.doc_prog == DOC_FULL ||
                    (state.began_in_block && state.prev_type == TYPE_DOC)) begin
                    line_type = TYPE_DOC;
                end else begin
                    line_type = TYPE_COMMENT;
                end
            end else begin
                line_type = TYPE_CODE;
            end

            state_next.mode = in_block ? MODE_BLOCK : MODE_NORMAL;
            state_next.began_in_block = in_block;
            state_next.prev_type = line_type;
            state_next.prev_bs = state.last_bs;
            state_next.line_cnt = state.line_cnt + 16'd1;
            state_next.last_bs = 1'b0;
            state_next.doc_prog = 3'd0;
            state_next.lead = 1'b1;
            state_next.first_hash = 1'b0;
            state_next.has_content = 1'b0;
        end
    end

endmodule
